[src/text_console_writer_top_defines.svh]
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared concurrent check forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcw check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcw check failed");

`endif

[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Command codes, character constants and fixed field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CMD_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int POS_W    = 11;
	localparam int CELL_W   = 16;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd15;

	// register index, taken from paddr[2]
	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

endpackage

[src/tcw_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// Text console writer, top level
// ROWS x COLS character buffer with cursor, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot stall it. A put that needs no scroll and an unused command leave busy
// low, so a new command may be issued straight after them; a put that
// arrives with the cursor at the end of the screen (cursor_pos equal to
// ROWS*COLS) first scrolls; scroll, cell read and clear hold busy high.
// Scroll and clear are paced by the single write port of the cell RAM,
// which moves one cell per cycle during scroll and clear. After reset the
// block sweeps zeros through the RAM with busy high; register writes are
// accepted during that sweep.
`include "text_console_writer_top_defines.svh"

module text_console_writer_top
	import tcw_pkg::*;
#(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [IDX_W-1:0]   cell_index,
	// result channel
	output logic               done,
	output logic [POS_W-1:0]   cursor_pos,
	output logic [CHAR_W-1:0]  cell_char,
	output logic [CHAR_W-1:0]  cell_attr,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);       // cell address
	localparam int CUR_W = $clog2(CELLS + 1);   // cursor also holds CELLS
	localparam int COL_W = $clog2(COLS);
	localparam int CMPW  = (CUR_W > IDX_W) ? CUR_W : IDX_W;

	typedef enum logic [2:0] {
		ST_INIT,    // reset sweep, zeros
		ST_IDLE,
		ST_READ,    // waiting for read data
		ST_COPY,    // scroll: move rows up
		ST_FILL,    // scroll: blank bottom row
		ST_PUT,     // put held character after scroll
		ST_CLEAR    // clear sweep, spaces
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        cnt_q;
	logic [CUR_W-1:0]     cursor_q;
	logic [COL_W-1:0]     col_q;
	logic [CHAR_W-1:0]    attr_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 in_range_q;
	logic                 done_q;
	logic [CHAR_W-1:0]    cell_char_q;
	logic [CHAR_W-1:0]    cell_attr_q;

	// scroll copy write, registered from its read
	logic                 wr_vld_s1;
	logic [AW-1:0]        wr_addr_s1;

	logic                 accept;
	cmd_t                 cmd;
	logic                 cursor_end;
	logic                 idx_in_range;
	logic                 cfg_we;

	logic [CHAR_W-1:0]    put_ch;
	logic                 put_nl;
	logic [CUR_W-1:0]     put_cursor;
	logic [COL_W-1:0]     put_col;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [CELL_W-1:0]    ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [CELL_W-1:0]    ram_rdata;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign cmd          = cmd_t'(command);
	assign cursor_end   = (cursor_q == CUR_W'(CELLS));
	assign idx_in_range = (CMPW'(cell_index) < CMPW'(CELLS));

	assign done       = done_q;
	assign cursor_pos = POS_W'(cursor_q);
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

	// ---------------------------------------------------------------- registers
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);
	assign prdata = (paddr[2] == REG_TEXT_ATTR) ? PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= pwdata[CHAR_W-1:0];
		end
	end

	// ---------------------------------------------------------------- put step
	// Column is tracked beside the linear cursor, so a newline is a plain add
	// to the next row start and needs no divide by COLS.
	always_comb begin
		put_ch     = (state_q == ST_PUT) ? char_q : char_code;
		put_nl     = (put_ch == NEWLINE_CODE);
		put_cursor = put_nl ? cursor_q + (CUR_W'(COLS) - CUR_W'(col_q))
		                    : cursor_q + CUR_W'(1);
		put_col    = (put_nl || col_q == COL_W'(COLS - 1)) ? '0 : col_q + COL_W'(1);
	end

	// ---------------------------------------------------------------- RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = cnt_q + AW'(COLS);
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = {attr_q, SPACE_CODE};
			end
			ST_COPY: begin
				// read cell n+COLS, write cell n-1 from the previous read
				ram_re    = 1'b1;
				ram_we    = wr_vld_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				// last copy write drains first, then the bottom row blanks
				ram_we = 1'b1;
				if (wr_vld_s1) begin
					ram_waddr = wr_addr_s1;
					ram_wdata = ram_rdata;
				end else begin
					ram_wdata = {attr_q, SPACE_CODE};
				end
			end
			ST_PUT: begin
				ram_we    = !put_nl;
				ram_waddr = AW'(cursor_q);
				ram_wdata = {attr_q, put_ch};
			end
			ST_IDLE: begin
				if (accept && cmd == CMD_PUT && !cursor_end) begin
					ram_we    = !put_nl;
					ram_waddr = AW'(cursor_q);
					ram_wdata = {attr_q, put_ch};
				end
				if (accept && cmd == CMD_READ) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(cell_index);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- copy pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1  <= 1'b0;
			wr_addr_s1 <= '0;
		end else begin
			wr_vld_s1  <= (state_q == ST_COPY);
			wr_addr_s1 <= cnt_q;
		end
	end

	// ---------------------------------------------------------------- control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			cursor_q    <= '0;
			col_q       <= '0;
			char_q      <= '0;
			in_range_q  <= 1'b0;
			done_q      <= 1'b0;
			cell_char_q <= '0;
			cell_attr_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_PUT: begin
								if (cursor_end) begin
									char_q  <= char_code;
									cnt_q   <= '0;
									state_q <= ST_COPY;
								end else begin
									cursor_q    <= put_cursor;
									col_q       <= put_col;
									done_q      <= 1'b1;
									cell_char_q <= '0;
									cell_attr_q <= '0;
								end
							end
							CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							CMD_READ: begin
								in_range_q <= idx_in_range;
								state_q    <= ST_READ;
							end
							default: begin
								done_q      <= 1'b1;
								cell_char_q <= '0;
								cell_attr_q <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					done_q      <= 1'b1;
					cell_char_q <= in_range_q ? ram_rdata[CHAR_W-1:0] : '0;
					cell_attr_q <= in_range_q ? ram_rdata[CELL_W-1:CHAR_W] : '0;
					state_q     <= ST_IDLE;
				end
				ST_COPY: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(CELLS - COLS - 1)) begin
						cnt_q   <= AW'(CELLS - COLS);
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (!wr_vld_s1) begin
						cnt_q <= cnt_q + AW'(1);
						if (cnt_q == AW'(CELLS - 1)) begin
							// cursor drops back one row; column stays 0
							cursor_q <= CUR_W'(CELLS - COLS);
							state_q  <= ST_PUT;
						end
					end
				end
				ST_PUT: begin
					cursor_q    <= put_cursor;
					col_q       <= put_col;
					done_q      <= 1'b1;
					cell_char_q <= '0;
					cell_attr_q <= '0;
					state_q     <= ST_IDLE;
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(CELLS - 1)) begin
						cursor_q    <= '0;
						col_q       <= '0;
						done_q      <= 1'b1;
						cell_char_q <= '0;
						cell_attr_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	`TCW_ASSERT_SAME(a_cursor_bound, 1'b1, cursor_q <= CUR_W'(CELLS))
	`TCW_ASSERT_SAME(a_end_col_zero, cursor_end, col_q == '0)
	`TCW_ASSERT_NEXT(a_read_result, state_q == ST_READ, done_q && state_q == ST_IDLE)
	`TCW_ASSERT_SAME(a_ram_no_overlap, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

[dv/text_console_writer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, clear, read and unused commands with random idle gaps, keeps a
// shadow screen, cursor and attribute, and checks each result transaction
// field by field. The attribute register is rewritten between phases.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
	import tcw_pkg::*;

	localparam int ROWS           = 25;
	localparam int COLS           = 80;
	localparam int CELLS          = ROWS * COLS;
	// clear and scroll each hold busy while they step through every cell, and so
	// does the zero sweep after reset; the limit scales with CELLS to allow for that
	localparam int WATCHDOG_LIMIT = 10 * CELLS;
	localparam int TAIL_CYCLES    = 8;
	localparam logic [PADDR_W-1:0] ADDR_TEXT_ATTR = {REG_TEXT_ATTR, 2'b00};

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
	} console_reply_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   command;
	logic [CHAR_W-1:0]  char_code;
	logic [IDX_W-1:0]   cell_index;
	logic               done;
	logic [POS_W-1:0]   cursor_pos;
	logic [CHAR_W-1:0]  cell_char;
	logic [CHAR_W-1:0]  cell_attr;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// shadow copy of the console: attribute register, cells and cursor
	logic [CHAR_W-1:0]  text_attr;
	logic [CELL_W-1:0]  shadow_cells [CELLS];
	int                 shadow_cursor;
	int                 scrolls_done;

	console_reply_t     replies_due [$];
	int                 error_count;
	int                 quiet_cycles;
	bit                 no_idle;

	always #5ns clk = ~clk;

	text_console_writer_top #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.char_code  (char_code),
		.cell_index (cell_index),
		.done       (done),
		.cursor_pos (cursor_pos),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Updates the shadow console for one accepted command and returns the
	// result transaction it should produce.
	function automatic console_reply_t apply_console_command(cmd_t op,
			logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		console_reply_t reply;
		reply = '0;
		case (op)
			CMD_PUT: begin
				// pending scroll is resolved before the character lands
				if (shadow_cursor >= CELLS) begin
					for (int i = 0; i < CELLS - COLS; i++)
						shadow_cells[i] = shadow_cells[i + COLS];
					for (int i = CELLS - COLS; i < CELLS; i++)
						shadow_cells[i] = {text_attr, SPACE_CODE};
					shadow_cursor -= COLS;
					scrolls_done++;
				end
				if (ch == NEWLINE_CODE) begin
					shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
				end else begin
					shadow_cells[shadow_cursor] = {text_attr, ch};
					shadow_cursor++;
				end
			end
			CMD_CLEAR: begin
				foreach (shadow_cells[i])
					shadow_cells[i] = {text_attr, SPACE_CODE};
				shadow_cursor = 0;
			end
			CMD_READ: begin
				// out-of-range reads return zeros
				if (idx < CELLS) begin
					reply.cell_char = shadow_cells[idx][CHAR_W-1:0];
					reply.cell_attr = shadow_cells[idx][CELL_W-1:CHAR_W];
				end
			end
			default: begin
			end
		endcase
		reply.cursor_pos = POS_W'(shadow_cursor);
		return reply;
	endfunction

	// Cell a little behind the cursor, so reads mostly hit fresh text.
	function automatic logic [IDX_W-1:0] near_cursor_index();
		int c;
		c = shadow_cursor - 1 - int'($urandom_range(0, 2 * COLS));
		if (c < 0)
			c = $urandom_range(0, CELLS - 1);
		return IDX_W'(c);
	endfunction

	// One command transaction. start stays high straight into the next
	// command unless an idle gap is drawn.
	task automatic issue_command(cmd_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		start      <= 1'b1;
		command    <= op;
		char_code  <= ch;
		cell_index <= idx;
		do @(posedge clk); while (busy);
		replies_due.push_back(apply_console_command(op, ch, idx));
		if (!no_idle && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic wait_console_quiet();
		start <= 1'b0;
		while (replies_due.size() != 0 || busy) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic write_text_attribute(logic [CHAR_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word           = $urandom;
		word[CHAR_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TEXT_ATTR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		text_attr = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Screen is all zeros after the reset sweep; also out-of-range reads
	// and the unused command.
	task automatic test_after_reset();
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(0));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(CELLS - 1));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(CELLS));
		issue_command(CMD_READ, CHAR_W'($urandom), '1);
		issue_command(CMD_NONE, CHAR_W'($urandom), IDX_W'($urandom));
	endtask

	// Extreme bytes (null is an ordinary character), newline, read-back.
	task automatic test_put_and_read();
		issue_command(CMD_PUT, 8'h00, IDX_W'($urandom));
		issue_command(CMD_PUT, 8'hFF, IDX_W'($urandom));
		issue_command(CMD_PUT, 8'h41, IDX_W'($urandom));
		issue_command(CMD_PUT, NEWLINE_CODE, IDX_W'($urandom));
		issue_command(CMD_PUT, 8'h42, IDX_W'($urandom));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(0));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(1));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(3));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(COLS));
		issue_command(CMD_NONE, CHAR_W'($urandom), IDX_W'($urandom));
	endtask

	// Clear with attribute 0xFF, then a put with attribute 0x00; unused fields carry junk.
	task automatic test_clear();
		wait_console_quiet();
		write_text_attribute(8'hFF);
		issue_command(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(0));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(CELLS - 1));
		issue_command(CMD_PUT, 8'h43, IDX_W'($urandom));
		wait_console_quiet();
		write_text_attribute(8'h00);
		issue_command(CMD_PUT, 8'h44, IDX_W'($urandom));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(0));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(1));
		issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(2));
	endtask

	// Mostly short lines so the cursor runs off the bottom several times;
	// once, the last row is filled exactly so that wrap alone makes the
	// scroll pending, and a newline then lands on a pending scroll.
	task automatic test_scroll();
		logic [CHAR_W-1:0] ch;
		int                len;
		bit                row_filled;
		row_filled = 1'b0;
		wait_console_quiet();
		write_text_attribute(CHAR_W'($urandom));
		issue_command(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
		while (scrolls_done < 3) begin
			if (!row_filled && scrolls_done >= 1 && shadow_cursor >= CELLS - COLS
					&& shadow_cursor < CELLS) begin
				row_filled = 1'b1;
				while (shadow_cursor < CELLS) begin
					ch = CHAR_W'($urandom);
					if (ch == NEWLINE_CODE)
						ch = SPACE_CODE;
					issue_command(CMD_PUT, ch, IDX_W'($urandom));
				end
				issue_command(CMD_PUT, NEWLINE_CODE, IDX_W'($urandom));
				issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(CELLS - COLS - 1));
				issue_command(CMD_READ, CHAR_W'($urandom), IDX_W'(CELLS - 1));
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
				: $urandom_range(0, 4);
			repeat (len) begin
				ch = CHAR_W'($urandom);
				if (ch == NEWLINE_CODE)
					ch = SPACE_CODE;
				issue_command(CMD_PUT, ch, IDX_W'($urandom));
			end
			issue_command(CMD_PUT, NEWLINE_CODE, IDX_W'($urandom));
			if ($urandom_range(0, 3) == 0)
				issue_command(CMD_READ, CHAR_W'($urandom), near_cursor_index());
		end
	endtask

	// Random mix in phases; attribute changes between phases and one
	// phase runs with the sender never idling.
	task automatic test_random_mix(int phases, int per_phase);
		int r;
		for (int p = 0; p < phases; p++) begin
			wait_console_quiet();
			case (p)
				0:       write_text_attribute(8'h00);
				1:       write_text_attribute(8'hFF);
				default: write_text_attribute(CHAR_W'($urandom));
			endcase
			no_idle = (p == 1);
			repeat (per_phase) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					issue_command(CMD_PUT, CHAR_W'($urandom), IDX_W'($urandom));
				else if (r < 62)
					issue_command(CMD_PUT, NEWLINE_CODE, IDX_W'($urandom));
				else if (r < 74)
					issue_command(CMD_READ, CHAR_W'($urandom), near_cursor_index());
				else if (r < 84)
					issue_command(CMD_READ, CHAR_W'($urandom),
						IDX_W'($urandom_range(0, CELLS - 1)));
				else if (r < 89)
					issue_command(CMD_READ, CHAR_W'($urandom),
						IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1)));
				else if (r < 94)
					issue_command(CMD_NONE, CHAR_W'($urandom), IDX_W'($urandom));
				else if (r < 96)
					issue_command(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
				else
					issue_command(CMD_PUT, CHAR_W'($urandom_range(32, 126)),
						IDX_W'($urandom));
			end
			no_idle = 1'b0;
		end
	endtask

	// Every done is matched against the oldest outstanding expectation.
	always @(posedge clk) begin : check_replies
		console_reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("result with no command outstanding, cursor_pos %0d", cursor_pos);
				error_count++;
			end else begin
				want = replies_due.pop_front();
				if (cursor_pos !== want.cursor_pos) begin
					$error("cursor_pos expected %0d actual %0d", want.cursor_pos, cursor_pos);
					error_count++;
				end
				if (cell_char !== want.cell_char) begin
					$error("cell_char expected %0h actual %0h", want.cell_char, cell_char);
					error_count++;
				end
				if (cell_attr !== want.cell_attr) begin
					$error("cell_attr expected %0h actual %0h", want.cell_attr, cell_attr);
					error_count++;
				end
			end
		end
	end

	// Counts cycles with no transaction of any kind.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		error_count   = 0;
		no_idle       = 1'b0;
		scrolls_done  = 0;
		shadow_cursor = 0;
		text_attr     = ATTR_RESET;
		foreach (shadow_cells[i])
			shadow_cells[i] = '0;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		command    <= CMD_PUT;
		char_code  <= '0;
		cell_index <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_put_and_read();
		test_clear();
		test_scroll();
		test_random_mix(4, 60);

		wait_console_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && replies_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
